// ===== src/wio_pkg.sv =====
package wio_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int SAMPLE_BITS = 16;
  localparam int TIME_W      = 48;
  localparam int STEP_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int WIDX_W      = 10;
  localparam int TIDX_W      = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_WRITE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP   = 1'b0,
    CFG_TABLE_LENGTH = 1'b1
  } cfg_reg_t;

  // Item at the table stage: read pair for samples, write target for writes.
  typedef struct packed {
    logic                   valid;
    logic                   mode;
    logic [ADDR_W-1:0]      idx;
    logic [ADDR_W-1:0]      nxt;
    logic [FRAC_W-1:0]      frac;
    logic [SAMPLE_BITS-1:0] wval;
  } addr_stage_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIDX_W-1:0]      table_index;
  } out_item_t;

  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

endpackage

// ===== src/wio_in_if.sv =====
interface wio_in_if;
  logic                            valid;
  logic                            ready;
  logic [0:0]                      mode;
  logic [wio_pkg::TIME_W-1:0]      time_req;
  logic [wio_pkg::WIDX_W-1:0]      write_index;
  logic [wio_pkg::SAMPLE_BITS-1:0] write_value;

  modport source (output valid, output mode, output time_req, output write_index,
                  output write_value, input ready);
  modport sink   (input valid, input mode, input time_req, input write_index,
                  input write_value, output ready);
endinterface

// ===== src/wio_out_if.sv =====
interface wio_out_if;
  logic                            valid;
  logic                            ready;
  logic [wio_pkg::SAMPLE_BITS-1:0] sample;
  logic [wio_pkg::TIDX_W-1:0]      table_index;

  modport source (output valid, output sample, output table_index, input ready);
  modport sink   (input valid, input sample, input table_index, output ready);
endinterface

// ===== src/wavetable_interp_oscillator.sv =====
// Wavetable oscillator with linear interpolation.
//
// req carries one transaction per item. mode = 1 writes write_value into
// table entry write_index and yields no result. mode = 0 requests a sample at
// time_req: phase = frac(time_req * phase_step), the phase times the active
// table length gives the entry index and a 16-bit weight, and the block
// returns the floor-rounded blend of that entry and the next (wrapping to 0).
// rsp carries sample and table_index, one transaction per sample request.
//
// Throughput: one item per clock, set by a four-register pipeline (phase
// multiply, length multiply, dual-read table RAM, difference multiply); the
// blend is added as the result enters a two-entry output FIFO that feeds rsp.
// Stall: when rsp.ready is low the FIFO fills, then the pipeline holds and
// req.ready drops; nothing is lost, and it resumes when a transaction drains.
// Reset clears all control state, phase_step to 0 and table_length to 1024.
// The table itself is not cleared: read only entries that have been written.
// Write configuration only while no request is in flight.
module wavetable_interp_oscillator (
  input  logic                                clk,
  input  logic                                rst,
  wio_in_if.sink                              req,
  wio_out_if.source                           rsp,
  input  logic                                cfg_we,
  input  logic [wio_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wio_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int LW = wio_pkg::LEN_W;

  logic [wio_pkg::STEP_W-1:0] phase_step;
  logic [LW-1:0]              len;
  logic [LW-1:0]              len_raw;

  logic                            adv;
  logic                            accept;
  logic                            fifo_full;
  logic                            push;
  wio_pkg::addr_stage_t            stage;
  wio_pkg::out_item_t              push_item;
  wio_pkg::out_item_t              out_item;
  wio_pkg::ram_ctl_t               ram_ctl;
  logic [wio_pkg::SAMPLE_BITS-1:0] v1;
  logic [wio_pkg::SAMPLE_BITS-1:0] v2;

  // Configuration: clamp the length once at write time.
  assign len_raw = cfg_data[LW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      len        <= LW'(wio_pkg::TABLE_DEPTH);
    end else if (cfg_we) begin
      unique case (wio_pkg::cfg_reg_t'(cfg_index))
        wio_pkg::CFG_PHASE_STEP: begin
          phase_step <= cfg_data[wio_pkg::STEP_W-1:0];
        end
        wio_pkg::CFG_TABLE_LENGTH: begin
          if (len_raw == '0) begin
            len <= LW'(1);
          end else if (32'(len_raw) > 32'(wio_pkg::TABLE_DEPTH)) begin
            len <= LW'(wio_pkg::TABLE_DEPTH);
          end else begin
            len <= len_raw;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Advance the whole pipeline unless the output FIFO is full.
  assign adv       = !fifo_full;
  assign req.ready = adv;
  assign accept    = req.valid && adv;

  wio_addr_gen u_addr_gen (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .accept      (accept),
    .mode        (req.mode[0]),
    .time_req    (req.time_req),
    .write_index (req.write_index),
    .write_value (req.write_value),
    .phase_step  (phase_step),
    .len         (len),
    .stage       (stage)
  );

  // Writes and reads sit at the same pipeline stage, so program order holds.
  assign ram_ctl.we = adv && stage.valid && (stage.mode == wio_pkg::MODE_WRITE);
  assign ram_ctl.re = adv && stage.valid && (stage.mode == wio_pkg::MODE_SAMPLE);

  wio_table_ram #(
    .DEPTH (wio_pkg::TABLE_DEPTH),
    .WIDTH (wio_pkg::SAMPLE_BITS)
  ) u_table_ram (
    .clk    (clk),
    .we     (ram_ctl.we),
    .waddr  (stage.idx),
    .wdata  (stage.wval),
    .re     (ram_ctl.re),
    .raddr0 (stage.idx),
    .raddr1 (stage.nxt),
    .rdata0 (v1),
    .rdata1 (v2)
  );

  wio_interp u_interp (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .stage (stage),
    .v1    (v1),
    .v2    (v2),
    .push  (push),
    .item  (push_item)
  );

  wio_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .valid     (rsp.valid),
    .ready     (rsp.ready),
    .item      (out_item)
  );

  assign rsp.sample      = out_item.sample;
  assign rsp.table_index = out_item.table_index;

  // Sample reads stay inside the active table length.
  a_read_range: assert property (@(posedge clk) disable iff (rst)
    ram_ctl.re |-> ({1'b0, stage.idx} < len) && ({1'b0, stage.nxt} < len))
    else $error("table read outside active length");

  // A table access is either a write or a read pair, never both.
  a_ram_excl: assert property (@(posedge clk) disable iff (rst)
    !(ram_ctl.we && ram_ctl.re))
    else $error("table write and read in the same cycle");

  // The pipeline never pushes into a full FIFO.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_full)
    else $error("result pushed into full output FIFO");

  // Backpressure on req only appears while results wait on rsp.
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> rsp.valid)
    else $error("request stalled with no pending result");

endmodule

// ===== src/wio_table_ram.sv =====
module wio_table_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== src/wio_addr_gen.sv =====
module wio_addr_gen (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            accept,
  input  logic                            mode,
  input  logic [wio_pkg::TIME_W-1:0]      time_req,
  input  logic [wio_pkg::WIDX_W-1:0]      write_index,
  input  logic [wio_pkg::SAMPLE_BITS-1:0] write_value,
  input  logic [wio_pkg::STEP_W-1:0]      phase_step,
  input  logic [wio_pkg::LEN_W-1:0]       len,
  output wio_pkg::addr_stage_t            stage
);

  localparam int SW = wio_pkg::STEP_W;
  localparam int AW = wio_pkg::ADDR_W;
  localparam int LW = wio_pkg::LEN_W;

  // Phase stage registers
  logic                            valid0;
  logic                            mode0;
  logic [SW-1:0]                   phase0;
  logic [wio_pkg::WIDX_W-1:0]      widx0;
  logic [wio_pkg::SAMPLE_BITS-1:0] wval0;

  logic [2*SW-1:0] time_prod;
  logic [SW+LW-1:0] scaled;
  logic [AW-1:0]    idx;
  logic [LW-1:0]    idx_inc;
  logic             widx_ok;

  // Only the low 32 bits of time matter: the higher bits shift out of the fraction.
  assign time_prod = time_req[SW-1:0] * phase_step;
  assign scaled    = phase0 * len;
  assign idx       = scaled[SW+AW-1:SW];
  assign idx_inc   = {1'b0, idx} + LW'(1);
  assign widx_ok   = 32'(widx0) < 32'(wio_pkg::TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0      <= 1'b0;
      stage.valid <= 1'b0;
    end else if (adv) begin
      valid0      <= accept;
      stage.valid <= valid0 && ((mode0 == wio_pkg::MODE_SAMPLE) || widx_ok);
    end

    if (adv) begin
      mode0  <= mode;
      phase0 <= time_prod[SW-1:0];
      widx0  <= write_index;
      wval0  <= write_value;

      stage.mode <= mode0;
      stage.frac <= scaled[SW-1:SW-wio_pkg::FRAC_W];
      stage.wval <= wval0;
      if (mode0 == wio_pkg::MODE_WRITE) begin
        stage.idx <= AW'(widx0);
      end else begin
        stage.idx <= idx;
      end
      // wrap the second point to entry 0 past the last entry in use
      stage.nxt <= (idx_inc == len) ? '0 : idx_inc[AW-1:0];
    end
  end

endmodule

// ===== src/wio_interp.sv =====
module wio_interp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  wio_pkg::addr_stage_t            stage,
  input  logic [wio_pkg::SAMPLE_BITS-1:0] v1,
  input  logic [wio_pkg::SAMPLE_BITS-1:0] v2,
  output logic                            push,
  output wio_pkg::out_item_t              item
);

  localparam int SB = wio_pkg::SAMPLE_BITS;
  localparam int FW = wio_pkg::FRAC_W;
  localparam int PW = SB + 1 + FW + 1;

  logic                     valid2;
  logic [wio_pkg::ADDR_W-1:0] idx2;
  logic [FW-1:0]            frac2;

  logic                     valid3;
  logic [wio_pkg::ADDR_W-1:0] idx3;
  logic [SB-1:0]            v1_3;
  logic signed [PW-1:0]     prod3;

  logic signed [SB:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shifted;
  logic signed [SB+1:0] sum;

  assign diff    = $signed({v2[SB-1], v2}) - $signed({v1[SB-1], v1});
  assign prod    = diff * $signed({1'b0, frac2});
  // arithmetic shift floors toward minus infinity
  assign shifted = prod3 >>> FW;
  assign sum     = $signed({{2{v1_3[SB-1]}}, v1_3}) + shifted[SB+1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else if (adv) begin
      valid2 <= stage.valid && (stage.mode == wio_pkg::MODE_SAMPLE);
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx2  <= stage.idx;
      frac2 <= stage.frac;
      idx3  <= idx2;
      v1_3  <= v1;
      prod3 <= prod;
    end
  end

  assign push             = adv && valid3;
  assign item.sample      = sum[SB-1:0];
  assign item.table_index = wio_pkg::TIDX_W'(idx3);

endmodule

// ===== src/wio_out_fifo.sv =====
module wio_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wio_pkg::out_item_t push_item,
  output logic               full,
  output logic               valid,
  input  logic               ready,
  output wio_pkg::out_item_t item
);

  wio_pkg::out_item_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       pop;

  assign pop   = valid && ready;
  assign valid = (cnt != 2'd0);
  assign full  = (cnt == 2'd2);
  assign item  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

// ===== sim/osc_checker.sv =====
module osc_checker
  import wio_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  wio_in_if                     req,
  wio_out_if                    rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 100;

  logic [STEP_W-1:0]             step_q;
  logic [LEN_W-1:0]              len_q;
  logic signed [SAMPLE_BITS-1:0] wave_mem [TABLE_DEPTH];
  out_item_t                     expected_samples [$];
  int                            mismatches = 0;

  assign fail_count = mismatches;

  // Phase from time and step, then index and weight from phase times length.
  function automatic out_item_t interp_sample(logic [TIME_W-1:0] t);
    logic [TIME_W+STEP_W-1:0] turns;
    logic [STEP_W-1:0]        phase;
    logic [63:0]              scaled;
    int                       eff_len;
    int                       idx;
    int                       nxt;
    int                       frac;
    int                       v1;
    int                       v2;
    longint                   blend;
    out_item_t                r;
    turns = t * step_q;
    phase = turns[STEP_W-1:0];
    eff_len = int'(len_q);
    if (eff_len == 0) eff_len = 1;
    if (eff_len > TABLE_DEPTH) eff_len = TABLE_DEPTH;
    scaled = 64'(phase) * 64'(eff_len);
    idx = int'(scaled >> STEP_W);
    frac = int'(scaled[STEP_W-1:STEP_W-FRAC_W]);
    nxt = (idx + 1 >= eff_len) ? 0 : idx + 1;
    v1 = int'(wave_mem[idx]);
    v2 = int'(wave_mem[nxt]);
    // arithmetic shift of a signed product floors toward minus infinity
    blend = longint'(v2 - v1) * longint'(frac);
    r.sample = SAMPLE_BITS'(v1 + int'(blend >>> FRAC_W));
    r.table_index = TIDX_W'(idx);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < MAX_PRINTED)
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      step_q = '0;
      len_q = LEN_W'(TABLE_DEPTH);
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PHASE_STEP:   step_q = cfg_data[STEP_W-1:0];
          CFG_TABLE_LENGTH: len_q = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.mode == MODE_WRITE)
          wave_mem[req.write_index] = req.write_value;
        else
          expected_samples.push_back(interp_sample(req.time_req));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("result with no request waiting", $signed(rsp.sample), 0);
        end else begin
          want = expected_samples.pop_front();
          if (rsp.sample !== want.sample)
            report_mismatch("sample", $signed(rsp.sample), $signed(want.sample));
          if (rsp.table_index !== want.table_index)
            report_mismatch("table_index", rsp.table_index, want.table_index);
        end
      end
    end
    pending <= expected_samples.size();
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import wio_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 7;
  // Pipeline is four stages deep plus a two-entry FIFO; give writes time to land.
  localparam int LATENCY_PAD    = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 75;
  localparam int MAX_GAP        = 9;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  quiet;
  int                    fail_count;
  int                    pending;
  int                    idle_cycles;
  int                    stall_left;

  wio_in_if  req_if ();
  wio_out_if rsp_if ();

  wavetable_interp_oscillator dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  osc_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result side: after each transaction, draw a stall and hold ready low for
  // that many cycles. In quiet stretches keep ready high throughout.
  always @(posedge clk) begin
    int stall_draw;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      stall_draw = quiet ? 0 : $urandom_range(0, MAX_GAP);
      rsp_if.ready <= (stall_draw == 0);
      stall_left <= stall_draw;
    end else if (!rsp_if.ready) begin
      if (stall_left <= 1) rsp_if.ready <= 1'b1;
      stall_left <= stall_left - 1;
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Present one request transaction after a random gap and hold it until
  // accepted. With no gap, valid stays high straight into the next one.
  task automatic send(logic m, logic [TIME_W-1:0] t, logic [WIDX_W-1:0] wi,
                      logic [SAMPLE_BITS-1:0] wv);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= m;
    req_if.time_req <= t;
    req_if.write_index <= wi;
    req_if.write_value <= wv;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Unused payload fields carry random bits so every bit toggles.
  task automatic sample_at(logic [TIME_W-1:0] t);
    send(MODE_SAMPLE, t, WIDX_W'($urandom), SAMPLE_BITS'($urandom));
  endtask

  task automatic write_entry(logic [WIDX_W-1:0] wi, logic [SAMPLE_BITS-1:0] wv);
    send(MODE_WRITE, {16'($urandom), $urandom}, wi, wv);
  endtask

  // Drop valid, wait until every expected result has arrived, then let the
  // pipeline flush any trailing table writes for pad cycles.
  task automatic settle(int pad);
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  // Write both registers back to back, only once the block is idle.
  task automatic set_regs(logic [STEP_W-1:0] step, logic [LEN_W-1:0] len);
    settle(LATENCY_PAD);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PHASE_STEP;
    cfg_data <= CFG_DATA_W'(step);
    @(posedge clk);
    cfg_index <= CFG_TABLE_LENGTH;
    cfg_data <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mix small times, times near the top of the range, single bits and noise.
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 4))
      0:       return TIME_W'($urandom_range(0, 1023));
      1:       return '1 - TIME_W'($urandom_range(0, 1023));
      2:       return TIME_W'(1) << $urandom_range(0, TIME_W - 1);
      default: return {16'($urandom), $urandom};
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    logic [SAMPLE_BITS-1:0] wv;
    logic [STEP_W-1:0]      step;
    logic [LEN_W-1:0]       len;
    int                     pause_at;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_PHASE_STEP;
    cfg_data <= '0;
    quiet <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.mode <= MODE_SAMPLE;
    req_if.time_req <= '0;
    req_if.write_index <= '0;
    req_if.write_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole table first: the RAM is not cleared by reset, so no
    // sample may read an entry before it is written. Pin the first two and
    // the last entry to the extremes so the interpolation spans full scale.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      wv = (i == 0) ? 16'h8000 :
           (i == 1 || i == TABLE_DEPTH - 1) ? 16'h7FFF : SAMPLE_BITS'($urandom);
      write_entry(WIDX_W'(i), wv);
    end

    // Reset values written explicitly: zero step pins the phase at entry 0.
    set_regs('0, LEN_W'(TABLE_DEPTH));
    sample_at('0);
    sample_at('1);

    // Unit step: the largest time wraps to phase just below one cycle, so
    // the last entry blends toward entry 0 with the heaviest weight.
    set_regs(32'd1, LEN_W'(TABLE_DEPTH));
    sample_at('0);
    sample_at('1);
    sample_at(48'h1_0000_0000);
    sample_at(48'h0_7FFF_FFFF);

    // Full-scale step with an oversized length: clamp to the table depth.
    set_regs('1, '1);
    sample_at(48'd1);
    sample_at(48'd2);

    // Zero length acts as one entry; everything reads entry 0.
    set_regs(32'h8000_0000, '0);
    sample_at(48'd1);
    sample_at(48'h1234_5678_9ABC);

    // Two entries at opposite extremes: largest rising and falling blend.
    // Overwrite an entry and read it right behind the write, then restore.
    set_regs(32'h7FFF_FFFF, LEN_W'(2));
    sample_at(48'd0);
    sample_at(48'd1);
    sample_at(48'd2);
    write_entry(WIDX_W'(1), 16'h1234);
    sample_at(48'd1);
    write_entry(WIDX_W'(1), 16'h7FFF);
    sample_at(48'd2);

    // Random phases: new registers each time, mostly samples with some
    // table rewrites, one pause per phase until all results are back.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 4))
        0:       step = '0;
        1:       step = '1;
        2:       step = STEP_W'($urandom_range(1, 4096));
        default: step = $urandom;
      endcase
      case ($urandom_range(0, 6))
        0:       len = '0;
        1:       len = LEN_W'(1);
        2:       len = LEN_W'(2);
        3:       len = LEN_W'(TABLE_DEPTH);
        4:       len = LEN_W'($urandom_range(TABLE_DEPTH + 1, (1 << LEN_W) - 1));
        default: len = LEN_W'($urandom_range(1, TABLE_DEPTH));
      endcase
      set_regs(step, len);
      quiet <= ($urandom_range(0, 3) == 0);
      pause_at = $urandom_range(0, PHASE_ITEMS - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == pause_at) settle(0);
        if ($urandom_range(0, 3) == 0)
          write_entry(WIDX_W'($urandom), pick_value());
        else
          sample_at(pick_time());
      end
    end

    settle(2 * LATENCY_PAD);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
